// File: rtl/core/kmst_pkg.sv
// Shared types and constants for the Kruskal union-find block.
package kmst_pkg;

    localparam int VERTICES_DEF = 128;
    localparam int VTX_W        = 7;
    localparam int WEIGHT_W     = 16;
    localparam int TOTAL_W      = 23;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [VTX_W-1:0]    first_vertex;
        logic [VTX_W-1:0]    second_vertex;
        logic [WEIGHT_W-1:0] edge_weight;
        logic                last_edge;
    } kmst_in_t;

    typedef struct packed {
        logic                accepted;
        logic [WEIGHT_W-1:0] taken_weight;
        logic [TOTAL_W-1:0]  tree_total;
        logic                graph_done;
    } kmst_out_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch incoming word
        logic clr_start;   // restart clearing sweep, zero total
        logic clr_en;      // write one identity entry
        logic sel_b;       // walk works on second vertex
        logic walk_start;  // cur <= vertex, read its parent
        logic find_step;   // cur <= parent, read next parent
        logic save_root;   // cur is the root of the walk
        logic comp_step;   // point cur at root, move to parent
        logic link;        // join roots if they differ, add weight
        logic load_out;    // fill the result register
    } kmst_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_range;
        logic at_root;
        logic at_walk_root;
        logic clr_last;
        logic last_edge;   // word in work closes its graph
    } kmst_sts_t;

endpackage

// File: rtl/core/kmst_datapath.sv
// Datapath: parent memory, walk registers, running total and result register.
module kmst_datapath
    import kmst_pkg::*;
#(
    parameter int VERTICES = VERTICES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  kmst_cmd_t cmd,
    output kmst_sts_t sts,
    input  kmst_in_t  s_data,
    output kmst_out_t m_data
);

    localparam int AW = $clog2(VERTICES);

    logic [AW-1:0] mem [VERTICES];

    kmst_in_t          item_reg;
    logic [AW-1:0]     cur_reg, cur_next;
    logic [AW-1:0]     root_a_reg, root_b_reg;
    logic [AW-1:0]     rd_data_reg;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic              ok_reg;
    kmst_out_t         out_reg;

    logic [VTX_W-1:0]  vtx_sel;
    logic [AW-1:0]     vtx_addr, root_sel, rd_addr;
    logic              we;
    logic [AW-1:0]     wr_addr, wr_data;
    logic [TOTAL_W:0]  sum;

    always_comb begin
        vtx_sel  = cmd.sel_b ? item_reg.second_vertex : item_reg.first_vertex;
        vtx_addr = AW'(vtx_sel);
        root_sel = cmd.sel_b ? root_b_reg : root_a_reg;
        rd_addr  = cmd.walk_start ? vtx_addr : rd_data_reg;

        we      = 1'b0;
        wr_addr = cur_reg;
        wr_data = root_sel;
        if (cmd.clr_en) begin
            we      = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = clr_cnt_reg;
        end else if (cmd.comp_step) begin
            we      = 1'b1;
        end else if (cmd.link && (root_a_reg != root_b_reg)) begin
            we      = 1'b1;
            wr_addr = root_a_reg;
            wr_data = root_b_reg;
        end

        cur_next = cur_reg;
        if (cmd.walk_start) begin
            cur_next = vtx_addr;
        end else if (cmd.find_step || cmd.comp_step) begin
            cur_next = rd_data_reg;
        end

        clr_cnt_next = clr_cnt_reg;
        if (cmd.clr_start) begin
            clr_cnt_next = '0;
        end else if (cmd.clr_en) begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end

        sum = {1'b0, total_reg} + (TOTAL_W + 1)'(item_reg.edge_weight);
        total_next = total_reg;
        if (cmd.clr_start) begin
            total_next = '0;
        end else if (cmd.link && (root_a_reg != root_b_reg)) begin
            total_next = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        end

        sts.in_range     = (int'(item_reg.first_vertex) < VERTICES)
                        && (int'(item_reg.second_vertex) < VERTICES);
        sts.at_root      = (rd_data_reg == cur_reg);
        sts.at_walk_root = (cur_reg == root_sel);
        sts.clr_last     = (clr_cnt_reg == AW'(VERTICES - 1));
        sts.last_edge    = item_reg.last_edge;
    end

    // parent memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            total_reg   <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
            total_reg   <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (cmd.capture) begin
            item_reg <= s_data;
            ok_reg   <= 1'b0;
        end else if (cmd.link && (root_a_reg != root_b_reg)) begin
            ok_reg   <= 1'b1;
        end
        if (cmd.save_root) begin
            if (cmd.sel_b) begin
                root_b_reg <= cur_reg;
            end else begin
                root_a_reg <= cur_reg;
            end
        end
        if (cmd.load_out) begin
            out_reg.accepted     <= ok_reg;
            out_reg.taken_weight <= item_reg.edge_weight;
            out_reg.tree_total   <= total_reg;
            out_reg.graph_done   <= item_reg.last_edge;
        end
    end

    assign m_data = out_reg;

endmodule

// File: rtl/core/kmst_ctrl.sv
// Controller: sequences clearing sweep, root walks, compression, link and result.
module kmst_ctrl
    import kmst_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  kmst_sts_t sts,
    output kmst_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_FIND,
        ST_CSTART,
        ST_COMP,
        ST_LINK,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   sel_b_reg, sel_b_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        cmd.sel_b    = sel_b_reg;
        state_next   = state_reg;
        sel_b_next   = sel_b_reg;
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    sel_b_next  = 1'b0;
                    state_next  = ST_START;
                end
            end
            ST_START: begin
                if (!sts.in_range) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.walk_start = 1'b1;
                    state_next     = ST_FIND;
                end
            end
            ST_FIND: begin
                if (sts.at_root) begin
                    cmd.save_root = 1'b1;
                    state_next    = ST_CSTART;
                end else begin
                    cmd.find_step = 1'b1;
                end
            end
            ST_CSTART: begin
                cmd.walk_start = 1'b1;
                state_next     = ST_COMP;
            end
            ST_COMP: begin
                if (sts.at_walk_root) begin
                    if (sel_b_reg) begin
                        state_next = ST_LINK;
                    end else begin
                        sel_b_next = 1'b1;
                        state_next = ST_START;
                    end
                end else begin
                    cmd.comp_step = 1'b1;
                end
            end
            ST_LINK: begin
                cmd.link   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    if (sts.last_edge) begin
                        cmd.clr_start = 1'b1;
                        state_next    = ST_CLEAR;
                    end else begin
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            sel_b_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_b_reg   <= sel_b_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// File: rtl/core/kruskal_mst_union_find.sv
// Top level of the Kruskal minimum spanning tree union-find stage.
//
// Usage:
//  - s_ channel: one edge per word (two vertices, weight, last flag), weights
//    in nondecreasing order. m_ channel: one result word per edge (accepted,
//    echoed weight, running tree total, graph done).
//  - One edge is worked at a time. The result word is loaded once both
//    vertices have been walked to their roots and linked (each walk runs a
//    root search then a compression pass, one parent read a cycle from the
//    one-read one-write parent memory). Unless the edge was marked last, the
//    next edge can be taken in the cycle after the load. Path compression
//    keeps depths small. An edge with a vertex out of range skips the walks
//    and leaves the forest alone.
//  - After the edge marked last, the result is loaded and then a clearing
//    sweep rewrites every parent entry to itself, with s_ready low. The same
//    sweep runs straight after reset, so s_ready rises once it has written
//    the last entry.
//  - The result sits in an output register; a stalled receiver holds m_valid
//    and the word steady, while the next edge is still taken and worked. Only
//    its own result waits for the slot to free. Total saturates at full scale.
module kruskal_mst_union_find
    import kmst_pkg::*;
#(
    parameter int VERTICES = VERTICES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  kmst_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output kmst_out_t m_data
);

    kmst_cmd_t cmd;
    kmst_sts_t sts;

    kmst_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kmst_datapath #(
        .VERTICES (VERTICES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

// File: rtl/core/kmst_checker.sv
// Port-level checker for the Kruskal union-find block, with its bind.
module kmst_checker
    import kmst_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input kmst_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input kmst_out_t m_data
);

    // stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // reset starts the clearing sweep, so no word is taken next cycle
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("ready high straight after reset");

    // one edge in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while one is in work");

    // an accepted edge is included in the total
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.accepted |-> m_data.tree_total >= TOTAL_W'(m_data.taken_weight))
        else $error("total below weight of an accepted edge");

endmodule

bind kruskal_mst_union_find kmst_checker u_kmst_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
